/* src/sdfv_pkg.sv */
package sdfv_pkg;

  localparam int GRID_RES_DEF = 64;
  localparam int COORD_W = 18;
  localparam int POS_W   = 31;   // grid_min + 1023*step fits
  localparam int DIFF_W  = 32;
  localparam int MAG_W   = 31;
  localparam int SQ_W    = 64;
  localparam int ROOT_W  = 32;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_Q_W = 18;   // quotient bits for all four divider lanes
  localparam int FIELD_ONE  = 65536;
  localparam int FIELD_HALF = 32768;
  localparam int GRAD_ONE   = 16384;

  typedef enum logic [2:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_CENTER_Z  = 3'd2,
    REG_INNER_R   = 3'd3,
    REG_FALLOFF   = 3'd4,
    REG_GRID_MIN  = 3'd5,
    REG_GRID_STEP = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [5:0] index_x;
    logic [5:0] index_y;
    logic [5:0] index_z;
  } in_req_t;

  typedef struct packed {
    logic [16:0]        field_value;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic signed [15:0] grad_z;
    logic               at_center;
  } out_res_t;

  // Payload carried beside the arithmetic through the square-root cell chain.
  typedef struct packed {
    logic                     vld;
    logic [2:0]               neg;      // sign of dx,dy,dz
    logic [2:0][MAG_W-1:0]    mag;      // |dx|,|dy|,|dz|
    logic                     zero;     // S == 0
  } side_t;

endpackage

/* src/sphere_distance_field_voxel.sv */
// Sphere distance field, one voxel index triple per request. A request is taken
// on any cycle with start high; busy stays low, so one voxel per clock is
// sustained. Each request yields exactly one result, shown for one cycle with
// out_valid high after 3 front stages, 32 square-root cells, 1 setup stage,
// 18 divider cells and 1 output stage. The receiver cannot stall the result.
// The pipeline depth is set mostly by the two cell chains: a digit-per-cell
// square root and a bit-per-cell divider shared by the three gradient lanes
// and the field lane. Write configuration only while no request is in flight.
module sphere_distance_field_voxel
  import sdfv_pkg::*;
#(
  parameter int GRID_RES = GRID_RES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_req,
  output logic        out_valid,
  output out_res_t    out_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  // Indices are 6 bits wide, so a grid wider than 64 never saturates.
  localparam logic [5:0] IDX_MAX = (GRID_RES > 64) ? 6'd63 : 6'(GRID_RES - 1);
  localparam int NUM_W = 50;
  localparam int DEN_W = 34;

  // Configuration registers.
  logic signed [17:0] cx_r, cy_r, cz_r, gmin_r;
  logic [16:0]        r1_r, r2_r, step_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; cz_r <= '0;
      r1_r <= 17'd4096; r2_r <= 17'd4096;
      gmin_r <= -18'sd4096; step_r <= 17'd130;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_CENTER_X:  cx_r   <= cfg_data[17:0];
        REG_CENTER_Y:  cy_r   <= cfg_data[17:0];
        REG_CENTER_Z:  cz_r   <= cfg_data[17:0];
        REG_INNER_R:   r1_r   <= cfg_data[16:0];
        REG_FALLOFF:   r2_r   <= cfg_data[16:0];
        REG_GRID_MIN:  gmin_r <= cfg_data[17:0];
        REG_GRID_STEP: step_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Stage 1: saturate indices, multiply by step.
  logic              s1_vld_r;
  logic [2:0][26:0]  s1_prod_r;
  logic [2:0][5:0]   idx_sat;

  always_comb begin
    idx_sat[0] = (in_req.index_x > IDX_MAX) ? IDX_MAX : in_req.index_x;
    idx_sat[1] = (in_req.index_y > IDX_MAX) ? IDX_MAX : in_req.index_y;
    idx_sat[2] = (in_req.index_z > IDX_MAX) ? IDX_MAX : in_req.index_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start;
    for (int a = 0; a < 3; a++) s1_prod_r[a] <= 27'(idx_sat[a]) * 27'(step_r);
  end

  // Stage 2: position minus centre, absolute value.
  logic               s2_vld_r;
  logic [2:0]         s2_neg_r;
  logic [2:0][MAG_W-1:0] s2_mag_r;
  logic signed [DIFF_W-1:0] diff [3];
  logic signed [17:0] ctr [3];

  always_comb begin
    ctr[0] = cx_r; ctr[1] = cy_r; ctr[2] = cz_r;
    for (int a = 0; a < 3; a++)
      diff[a] = DIFF_W'(gmin_r) + $signed({5'd0, s1_prod_r[a]}) - DIFF_W'(ctr[a]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
    for (int a = 0; a < 3; a++) begin
      s2_neg_r[a] <= diff[a][DIFF_W-1];
      s2_mag_r[a] <= diff[a][DIFF_W-1] ? MAG_W'(-diff[a]) : MAG_W'(diff[a]);
    end
  end

  // Stage 3: squares summed (each magnitude under 24 bits, so each square under 48 bits wide).
  logic [SQ_W-1:0] s3_sum_r;
  side_t           s3_side_r;
  logic [SQ_W-1:0] sum;

  always_comb begin
    sum = SQ_W'(s2_mag_r[0]) * SQ_W'(s2_mag_r[0]) + SQ_W'(s2_mag_r[1]) * SQ_W'(s2_mag_r[1])
        + SQ_W'(s2_mag_r[2]) * SQ_W'(s2_mag_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_side_r.vld <= 1'b0;
    else        s3_side_r.vld <= s2_vld_r;
    s3_side_r.neg  <= s2_neg_r;
    s3_side_r.mag  <= s2_mag_r;
    s3_side_r.zero <= (sum == '0);
    s3_sum_r       <= sum;
  end

  // Square root chain.
  logic [SQ_W-1:0]   sq_rem  [SQRT_STAGES+1];
  logic [ROOT_W-1:0] sq_root [SQRT_STAGES+1];
  side_t             sq_side [SQRT_STAGES+1];

  assign sq_rem[0]  = s3_sum_r;
  assign sq_root[0] = '0;
  assign sq_side[0] = s3_side_r;

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    sdfv_sqrt_cell #(.STAGE(g)) u_cell (
      .clk, .rst_n,
      .rem_i(sq_rem[g]), .root_i(sq_root[g]), .side_i(sq_side[g]),
      .rem_o(sq_rem[g+1]), .root_o(sq_root[g+1]), .side_o(sq_side[g+1])
    );
  end

  // Setup stage: build divider operands.
  logic [ROOT_W-1:0] d;
  side_t             sqs;
  logic signed [33:0] fnum;
  logic [33:0]       fmag;
  logic [3:0][NUM_W-1:0] dv_num  [DIV_Q_W+1];
  logic [3:0][DEN_W-1:0] dv_den  [DIV_Q_W+1];
  logic [3:0][DIV_Q_W-1:0] dv_quo [DIV_Q_W+1];
  logic [7:0]            dv_tag  [DIV_Q_W+1];
  logic                  dv_vld  [DIV_Q_W+1];
  logic [3:0][NUM_W-1:0] su_num_r;
  logic [3:0][DEN_W-1:0] su_den_r;
  logic [7:0]            su_tag_r;
  logic                  su_vld_r;

  assign d    = sq_root[SQRT_STAGES];
  assign sqs  = sq_side[SQRT_STAGES];
  assign fnum = $signed({2'b00, d}) - $signed({17'd0, r1_r});
  assign fmag = fnum[33] ? 34'(-fnum) : 34'(fnum);

  always_ff @(posedge clk) begin
    if (!rst_n) su_vld_r <= 1'b0;
    else        su_vld_r <= sqs.vld;
    for (int a = 0; a < 3; a++) begin
      su_num_r[a] <= (NUM_W'(sqs.mag[a]) << 15) + NUM_W'(d);
      su_den_r[a] <= sqs.zero ? DEN_W'(1) : {1'b0, d, 1'b0};
    end
    su_num_r[3] <= (NUM_W'(fmag) << 16) + NUM_W'(r2_r);
    su_den_r[3] <= (r2_r == '0) ? DEN_W'(1) : DEN_W'({r2_r, 1'b0});
    // tag: neg[2:0], zero, fsign, fzero, r2zero
    su_tag_r <= {1'b0, sqs.neg, sqs.zero, fnum[33], (fnum == '0), (r2_r == '0)};
  end

  assign dv_num[0] = su_num_r;
  assign dv_den[0] = su_den_r;
  assign dv_quo[0] = '0;
  assign dv_tag[0] = su_tag_r;
  assign dv_vld[0] = su_vld_r;

  for (genvar g = 0; g < DIV_Q_W; g++) begin : g_div
    sdfv_div_cell #(.STAGE(g), .NUM_W(NUM_W), .DEN_W(DEN_W)) u_cell (
      .clk, .rst_n,
      .num_i(dv_num[g]), .den_i(dv_den[g]), .quo_i(dv_quo[g]),
      .tag_i(dv_tag[g]), .vld_i(dv_vld[g]),
      .num_o(dv_num[g+1]), .den_o(dv_den[g+1]), .quo_o(dv_quo[g+1]),
      .tag_o(dv_tag[g+1]), .vld_o(dv_vld[g+1])
    );
  end

  // Output stage: clamp, sign, special cases.
  logic [3:0][DIV_Q_W-1:0] q;
  logic [7:0]              tg;
  logic [DIV_Q_W-1:0]      gq [3];
  logic signed [19:0]      fv;
  out_res_t                res;

  assign q  = dv_quo[DIV_Q_W];
  assign tg = dv_tag[DIV_Q_W];

  always_comb begin
    fv = '0;
    for (int a = 0; a < 3; a++)
      gq[a] = (q[a] > DIV_Q_W'(GRAD_ONE)) ? DIV_Q_W'(GRAD_ONE) : q[a];
    res.at_center = tg[3];
    res.grad_x = tg[3] ? '0 : (tg[4] ? -16'(gq[0]) : 16'(gq[0]));
    res.grad_y = tg[3] ? '0 : (tg[5] ? -16'(gq[1]) : 16'(gq[1]));
    res.grad_z = tg[3] ? '0 : (tg[6] ? -16'(gq[2]) : 16'(gq[2]));
    if (tg[0]) begin
      res.field_value = tg[2] ? 17'(FIELD_ONE) : (tg[1] ? 17'(FIELD_HALF) : 17'd0);
    end else begin
      // quotient saturates at 18 bits, well past the clamp points
      fv = tg[2] ? 20'sd32768 + $signed({2'b00, q[3]}) : 20'sd32768 - $signed({2'b00, q[3]});
      if (fv < 0)                    res.field_value = '0;
      else if (fv > 20'sd65536)      res.field_value = 17'(FIELD_ONE);
      else                           res.field_value = fv[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= dv_vld[DIV_Q_W];
    out_res <= res;
  end
endmodule

/* src/sdfv_sqrt_cell.sv */
// One digit of a restoring integer square root.
module sdfv_sqrt_cell
  import sdfv_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SQ_W-1:0]   rem_i,
  input  logic [ROOT_W-1:0] root_i,
  input  side_t             side_i,
  output logic [SQ_W-1:0]   rem_o,
  output logic [ROOT_W-1:0] root_o,
  output side_t             side_o
);
  localparam int SH = 2 * (ROOT_W - 1 - STAGE);

  logic [SQ_W+1:0]   trial;
  logic [SQ_W-1:0]   rem_nxt;
  logic [ROOT_W-1:0] root_nxt;

  always_comb begin
    // candidate = (4*root + 1) << SH
    trial = (SQ_W+2)'({root_i, 2'b01}) << SH;
    if ({2'b00, rem_i} >= trial) begin
      rem_nxt  = rem_i - trial[SQ_W-1:0];
      root_nxt = {root_i[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_i;
      root_nxt = {root_i[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_o.vld <= 1'b0;
    end else begin
      side_o.vld <= side_i.vld;
    end
    side_o.neg  <= side_i.neg;
    side_o.mag  <= side_i.mag;
    side_o.zero <= side_i.zero;
    rem_o       <= rem_nxt;
    root_o      <= root_nxt;
  end
endmodule

/* src/sdfv_div_cell.sv */
// One quotient bit of four parallel restoring divides sharing a stage.
// Lanes 0..2 divide gradient numerators by 2d, lane 3 the field numerator by 2r2.
module sdfv_div_cell
  import sdfv_pkg::*;
#(
  parameter int STAGE = 0,
  parameter int NUM_W = 50,
  parameter int DEN_W = 34
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [3:0][NUM_W-1:0]         num_i,
  input  logic [3:0][DEN_W-1:0]         den_i,
  input  logic [3:0][DIV_Q_W-1:0]       quo_i,
  input  logic [7:0]                    tag_i,
  input  logic                          vld_i,
  output logic [3:0][NUM_W-1:0]         num_o,
  output logic [3:0][DEN_W-1:0]         den_o,
  output logic [3:0][DIV_Q_W-1:0]       quo_o,
  output logic [7:0]                    tag_o,
  output logic                          vld_o
);
  localparam int SH = DIV_Q_W - 1 - STAGE;

  logic [3:0][NUM_W-1:0]   num_nxt;
  logic [3:0][DIV_Q_W-1:0] quo_nxt;
  logic [NUM_W-1:0]        trial;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      trial = NUM_W'(den_i[l]) << SH;
      if (num_i[l] >= trial) begin
        num_nxt[l] = num_i[l] - trial;
        quo_nxt[l] = {quo_i[l][DIV_Q_W-2:0], 1'b1};
      end else begin
        num_nxt[l] = num_i[l];
        quo_nxt[l] = {quo_i[l][DIV_Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
    num_o <= num_nxt;
    den_o <= den_i;
    quo_o <= quo_nxt;
    tag_o <= tag_i;
  end
endmodule

/* test/sdfv_checker.sv */
module sdfv_checker
  import sdfv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_req_t     in_req,
  input  logic        out_valid,
  input  out_res_t    out_res,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          accepted_reqs,
  output int          accepted_res,
  output int          center_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  longint cen_x, cen_y, cen_z, r_inner, r_fall, g_min, g_step;
  out_res_t voxel_q[$];

  function automatic longint sx18(logic [31:0] v);
    return longint'(signed'(v[17:0]));
  endfunction

  function automatic longint int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [15:0] unit_grad(longint c, longint d);
    longint q;
    q = ((c < 0 ? -c : c) * 32768 + d) / (2 * d);
    if (q > 16384) q = 16384;
    return (c < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic longint coord(logic [5:0] i);
    return g_min + longint'(i) * g_step;
  endfunction

  function automatic out_res_t voxel_predict(in_req_t r);
    out_res_t o;
    longint dx, dy, dz, s, d, num, t, f;
    dx = coord(r.index_x) - cen_x;
    dy = coord(r.index_y) - cen_y;
    dz = coord(r.index_z) - cen_z;
    s = dx * dx + dy * dy + dz * dz;
    d = int_sqrt(s);
    num = d - r_inner;
    o = '0;
    if (s == 0) begin
      o.at_center = 1'b1;
    end else begin
      o.grad_x = unit_grad(dx, d);
      o.grad_y = unit_grad(dy, d);
      o.grad_z = unit_grad(dz, d);
    end
    if (r_fall == 0) begin
      f = (num < 0) ? 65536 : (num == 0 ? 32768 : 0);
    end else begin
      t = ((num < 0 ? -num : num) * 65536 + r_fall) / (2 * r_fall);
      f = 32768 - ((num < 0) ? -t : t);
      if (f < 0) f = 0;
      if (f > 65536) f = 65536;
    end
    o.field_value = 17'(f);
    return o;
  endfunction

  assign pending = voxel_q.size();

  always @(posedge clk) begin
    out_res_t e;
    if (!rst_n) begin
      cen_x <= 0; cen_y <= 0; cen_z <= 0;
      r_inner <= 4096; r_fall <= 4096; g_min <= -4096; g_step <= 130;
      fail_count <= 0; accepted_reqs <= 0; accepted_res <= 0; center_hits <= 0;
      voxel_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_CENTER_X:  cen_x   <= sx18(cfg_data);
          REG_CENTER_Y:  cen_y   <= sx18(cfg_data);
          REG_CENTER_Z:  cen_z   <= sx18(cfg_data);
          REG_INNER_R:   r_inner <= longint'(cfg_data[16:0]);
          REG_FALLOFF:   r_fall  <= longint'(cfg_data[16:0]);
          REG_GRID_MIN:  g_min   <= sx18(cfg_data);
          REG_GRID_STEP: g_step  <= longint'(cfg_data[16:0]);
          default: ;
        endcase
      end
      if (out_valid) begin
        accepted_res <= accepted_res + 1;
        if (voxel_q.size() == 0) begin
          $error("result with no request waiting");
          fail_count <= fail_count + 1;
        end else begin
          e = voxel_q.pop_front();
          if (e.at_center) center_hits <= center_hits + 1;
          if (out_res != e) begin
            fail_count <= fail_count + 1;
            if (out_res.field_value != e.field_value)
              $error("field_value exp %0d got %0d", e.field_value, out_res.field_value);
            if (out_res.grad_x != e.grad_x)
              $error("grad_x exp %0d got %0d", e.grad_x, out_res.grad_x);
            if (out_res.grad_y != e.grad_y)
              $error("grad_y exp %0d got %0d", e.grad_y, out_res.grad_y);
            if (out_res.grad_z != e.grad_z)
              $error("grad_z exp %0d got %0d", e.grad_z, out_res.grad_z);
            if (out_res.at_center != e.at_center)
              $error("at_center exp %0d got %0d", e.at_center, out_res.at_center);
          end
        end
      end
      // Config is only written while idle, so prediction uses current registers.
      if (start && !busy) begin
        voxel_q.push_back(voxel_predict(in_req));
        accepted_reqs <= accepted_reqs + 1;
      end
    end
  end
endmodule

/* test/tb_sphere_distance_field_voxel.sv */
module tb_sphere_distance_field_voxel;
  import sdfv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT  = 55;
  localparam int IDLE_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_req_t     in_req = '0;
  logic        out_valid;
  out_res_t    out_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count, pending, n_req, n_res, n_center;
  int          idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sphere_distance_field_voxel u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sdfv_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .accepted_reqs(n_req),
    .accepted_res(n_res), .center_hits(n_center)
  );

  // Watchdog: count cycles in which no request, result or register write moves.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress in %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Write one register through the config channel; hold until accepted,
  // then drop valid before returning so the next write raises valid afresh.
  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Send one voxel request; hold start until taken. Start stays high when
  // another request follows directly, so it is never dropped and raised in one step.
  task automatic send_voxel(logic [5:0] ix, logic [5:0] iy, logic [5:0] iz, bit last);
    start  <= 1'b1;
    in_req <= '{index_x: ix, index_y: iy, index_z: iz};
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (last) start <= 1'b0;
  endtask

  // Drain: wait for every expected result, then the pipeline depth again.
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (PIPE_LAT + 5) @(negedge clk);
  endtask

  // Burst of random voxels with random gaps.
  task automatic random_burst(int count);
    int left, blen, gap;
    left = count;
    while (left > 0) begin
      blen = $urandom_range(1, 40);
      if (blen > left) blen = left;
      if ($urandom_range(0, 3) == 0) blen = 1;
      left -= blen;
      gap = ($urandom_range(0, 2) != 0) ? int'($urandom_range(1, 12)) : 0;
      // Keep start high into the next burst when no gap follows.
      for (int k = 0; k < blen; k++)
        send_voxel(6'($urandom), 6'($urandom), 6'($urandom),
                   (k == blen - 1) && (gap != 0 || left == 0));
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic random_config(int kind);
    logic [16:0] step;
    logic [17:0] gmin;
    case (kind)
      0: begin
        step = 17'($urandom_range(1, 600));
        gmin = 18'(-int'($urandom_range(0, 40000)));
      end
      1: begin
        step = 17'($urandom_range(1, 131071));
        gmin = 18'($urandom);
      end
      default: begin
        step = 17'($urandom_range(0, 4));
        gmin = 18'($urandom);
      end
    endcase
    reg_write(REG_GRID_STEP, {15'($urandom), step});
    reg_write(REG_GRID_MIN, {14'($urandom), gmin});
    reg_write(REG_CENTER_X, {14'($urandom), 18'(int'(gmin) + step * $urandom_range(0, 63))});
    reg_write(REG_CENTER_Y, {14'($urandom), 18'(int'(gmin) + step * $urandom_range(0, 63))});
    reg_write(REG_CENTER_Z, $urandom);
    reg_write(REG_INNER_R, 32'($urandom_range(0, 131071)));
    reg_write(REG_FALLOFF, ($urandom_range(0, 5) == 0) ? 32'd0 : 32'($urandom_range(1, 131071)));
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset config, corners of the grid and other points.
    send_voxel(6'd0, 6'd0, 6'd0, 0);
    send_voxel(6'd63, 6'd63, 6'd63, 0);
    send_voxel(6'd0, 6'd63, 6'd21, 0);
    send_voxel(6'h2A, 6'h15, 6'h3F, 1);
    drain();
    // Center on a grid point: hit it exactly, and its neighbors.
    reg_write(REG_GRID_MIN, 32'h3_0000);   // -16.0
    reg_write(REG_GRID_STEP, 32'd4096);
    reg_write(REG_CENTER_X, 32'h3_0000 + 32'd4096 * 5);
    reg_write(REG_CENTER_Y, 32'h3_0000 + 32'd4096 * 5);
    reg_write(REG_CENTER_Z, 32'h3_0000 + 32'd4096 * 5);
    reg_write(REG_INNER_R, 32'd0);
    reg_write(REG_FALLOFF, 32'd1);
    send_voxel(6'd5, 6'd5, 6'd5, 0);
    send_voxel(6'd6, 6'd5, 6'd5, 0);
    send_voxel(6'd5, 6'd4, 6'd5, 0);
    send_voxel(6'd63, 6'd0, 6'd63, 1);
    drain();
    // Hard step: zero falloff width, sample inside, on and outside the radius.
    reg_write(REG_FALLOFF, 32'd0);
    reg_write(REG_INNER_R, 32'd4096 * 2);
    send_voxel(6'd5, 6'd5, 6'd5, 0);
    send_voxel(6'd7, 6'd5, 6'd5, 0);
    send_voxel(6'd9, 6'd5, 6'd5, 1);
    drain();
    // Zero grid step, max step, max radius and falloff, max and min center.
    reg_write(REG_GRID_STEP, 32'd0);
    reg_write(REG_INNER_R, 32'h1_FFFF);
    reg_write(REG_FALLOFF, 32'h1_FFFF);
    reg_write(REG_CENTER_X, 32'h1_FFFF);
    send_voxel(6'd63, 6'd17, 6'd40, 1);
    drain();
    reg_write(REG_GRID_STEP, 32'h1_FFFF);
    reg_write(REG_GRID_MIN, 32'h1_FFFF);
    reg_write(REG_CENTER_Y, 32'h2_0000);
    send_voxel(6'd63, 6'd63, 6'd63, 0);
    send_voxel(6'd0, 6'd0, 6'd0, 0);
    send_voxel(6'd32, 6'd1, 6'd62, 1);
    drain();
    // Unknown register index must be ignored.
    reg_write(reg_idx_t'(3'd7), 32'hFFFF_FFFF);
    send_voxel(6'd3, 6'd3, 6'd3, 1);
    drain();

    // Random phases: new settings, then bursts; the drain also serves as
    // the full pause until every outstanding result has come back.
    for (int ph = 0; ph < 12; ph++) begin
      random_config(ph % 3);
      random_burst(120);
      drain();
    end

    $display("covered %0d voxel requests, %0d results, %0d at the sphere center",
             n_req, n_res, n_center);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
